### sv/c2dpad_pkg.sv
`default_nettype none
package c2dpad_pkg;

    // field and register widths
    localparam int OP_W        = 2;
    localparam int COORD_W     = 6;
    localparam int VALUE_W     = 16;
    localparam int PROD_W      = 32;
    localparam int RESULT_W    = 40;
    localparam int IMG_SIZE_W  = 7;
    localparam int MASK_SIZE_W = 3;
    localparam int CFG_W       = 7;
    localparam int CFG_IDX_W   = 1;

    // opcodes
    localparam logic [OP_W-1:0] OP_WR_MASK  = 2'd0;
    localparam logic [OP_W-1:0] OP_WR_IMAGE = 2'd1;
    localparam logic [OP_W-1:0] OP_COMPUTE  = 2'd2;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_SIZE = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_MASK_SIZE  = 1'b1;

    localparam logic [IMG_SIZE_W-1:0]  IMAGE_SIZE_RST = 7'd4;
    localparam logic [MASK_SIZE_W-1:0] MASK_SIZE_RST  = 3'd3;

    // padding select for one tap
    localparam logic [1:0] PAD_PIXEL = 2'd0;
    localparam logic [1:0] PAD_ONE   = 2'd1;
    localparam logic [1:0] PAD_ZERO  = 2'd2;

    localparam logic signed [VALUE_W-1:0] PAD_ONE_VALUE = 16'sd256;

    typedef struct packed {
        logic       valid;
        logic       last;
        logic [1:0] pad;
    } t_tap;

endpackage
`default_nettype wire

### sv/c2dpad_ram.sv
`default_nettype none
module c2dpad_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule
`default_nettype wire

### sv/c2dpad_seq.sv
`default_nettype none
module c2dpad_seq #(
    parameter int MAX_N = 64,
    parameter int MAX_M = 7,
    parameter int IAW   = 12,
    parameter int TAW   = 6
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_go,
    input  wire logic [c2dpad_pkg::COORD_W-1:0]      i_row,
    input  wire logic [c2dpad_pkg::COORD_W-1:0]      i_col,
    input  wire logic [c2dpad_pkg::IMG_SIZE_W-1:0]   i_image_size,
    input  wire logic [c2dpad_pkg::MASK_SIZE_W-1:0]  i_mask_size,
    input  wire logic                                i_done,
    output logic                                     o_busy,
    output c2dpad_pkg::t_tap                         o_tap,
    output logic [TAW-1:0]                           o_mask_raddr,
    output logic [IAW-1:0]                           o_image_raddr
);
    import c2dpad_pkg::*;

    localparam int MW = $clog2(MAX_M + 1);
    localparam int CW = 9;

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_RUN   = 2'd1;
    localparam logic [1:0] ST_DRAIN = 2'd2;

    logic [1:0]            r_state, n_state;
    logic [MW-1:0]         r_a, n_a, r_b, n_b;
    logic [MW-1:0]         r_m, r_h;
    logic [IMG_SIZE_W-1:0] r_n;
    logic [COORD_W-1:0]    r_row, r_col;

    logic [IMG_SIZE_W-1:0] s_n_eff;
    logic [MW-1:0]         s_m_eff;
    logic                  s_last;
    logic signed [CW-1:0]  s_pr, s_pc;
    logic                  s_row_out, s_col_out;

    // clamp sizes into the supported range
    always_comb begin
        if (i_image_size == '0) begin
            s_n_eff = IMG_SIZE_W'(1);
        end else if (32'(i_image_size) > MAX_N) begin
            s_n_eff = IMG_SIZE_W'(MAX_N);
        end else begin
            s_n_eff = i_image_size;
        end
        if (i_mask_size == '0) begin
            s_m_eff = MW'(1);
        end else if (32'(i_mask_size) > MAX_M) begin
            s_m_eff = MW'(MAX_M);
        end else begin
            s_m_eff = MW'(i_mask_size);
        end
    end

    assign s_last = (r_a == r_m - MW'(1)) && (r_b == r_m - MW'(1));

    always_comb begin
        n_state = r_state;
        n_a     = r_a;
        n_b     = r_b;
        case (r_state)
            ST_IDLE: begin
                if (i_go) begin
                    n_state = ST_RUN;
                    n_a     = '0;
                    n_b     = '0;
                end
            end
            ST_RUN: begin
                if (r_b == r_m - MW'(1)) begin
                    n_b = '0;
                    n_a = r_a + MW'(1);
                end else begin
                    n_b = r_b + MW'(1);
                end
                if (s_last) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (i_done) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_a     <= '0;
            r_b     <= '0;
        end else begin
            r_state <= n_state;
            r_a     <= n_a;
            r_b     <= n_b;
        end
    end

    // latch the job at start
    always_ff @(posedge i_clk) begin
        if (r_state == ST_IDLE && i_go) begin
            r_row <= i_row;
            r_col <= i_col;
            r_n   <= s_n_eff;
            r_m   <= s_m_eff;
            r_h   <= (s_m_eff - MW'(1)) >> 1;
        end
    end

    // image position under the current tap
    assign s_pr = $signed(CW'(r_row)) + $signed(CW'(r_a)) - $signed(CW'(r_h));
    assign s_pc = $signed(CW'(r_col)) + $signed(CW'(r_b)) - $signed(CW'(r_h));

    assign s_row_out = (s_pr < 0) || (s_pr >= $signed(CW'(r_n)));
    assign s_col_out = (s_pc < 0) || (s_pc >= $signed(CW'(r_n)));

    always_comb begin
        o_tap.valid = (r_state == ST_RUN);
        o_tap.last  = s_last;
        if (s_row_out && s_col_out) begin
            o_tap.pad = PAD_ZERO;
        end else if (s_row_out || s_col_out) begin
            o_tap.pad = PAD_ONE;
        end else begin
            o_tap.pad = PAD_PIXEL;
        end
    end

    assign o_mask_raddr  = TAW'(32'(r_a) * MAX_M + 32'(r_b));
    assign o_image_raddr = IAW'(32'(s_pr[CW-2:0]) * MAX_N + 32'(s_pc[CW-2:0]));
    assign o_busy        = (r_state != ST_IDLE);

endmodule
`default_nettype wire

### sv/c2dpad_mac.sv
`default_nettype none
module c2dpad_mac (
    input  wire logic                                    i_clk,
    input  wire logic                                    i_rst_n,
    input  c2dpad_pkg::t_tap                             i_tap,
    input  wire logic signed [c2dpad_pkg::VALUE_W-1:0]   i_tap_data,
    input  wire logic signed [c2dpad_pkg::VALUE_W-1:0]   i_pixel_data,
    output logic                                         o_done,
    output logic                                         o_result_valid,
    output logic signed [c2dpad_pkg::RESULT_W-1:0]       o_result_value
);
    import c2dpad_pkg::*;

    t_tap                        r_tap1;
    logic                        r_v2, r_last2;
    logic signed [PROD_W-1:0]    r_prod, n_prod;
    logic signed [RESULT_W-1:0]  r_acc, n_acc;
    logic signed [VALUE_W-1:0]   s_pix;

    // substitute padding for out-of-image pixels
    always_comb begin
        case (r_tap1.pad)
            PAD_PIXEL: s_pix = i_pixel_data;
            PAD_ONE:   s_pix = PAD_ONE_VALUE;
            default:   s_pix = '0;
        endcase
    end

    assign n_prod = PROD_W'(i_tap_data) * PROD_W'(s_pix);
    assign n_acc  = r_acc + RESULT_W'(r_prod);
    assign o_done = r_v2 && r_last2;

    always_ff @(posedge i_clk) begin
        r_prod  <= n_prod;
        r_last2 <= r_tap1.last;
        if (!i_rst_n) begin
            r_tap1         <= '0;
            r_v2           <= 1'b0;
            r_acc          <= '0;
            o_result_valid <= 1'b0;
        end else begin
            r_tap1         <= i_tap;
            r_v2           <= r_tap1.valid;
            o_result_valid <= o_done;
            if (r_v2) begin
                // clear after the last tap, ready for the next pixel
                r_acc <= r_last2 ? '0 : n_acc;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_done) begin
            o_result_value <= n_acc;
        end
    end

endmodule
`default_nettype wire

### sv/conv2d_edge_one_corner_zero_pad.sv
`default_nettype none
// Same-size square 2D convolution over a stored image and mask, Q8.8 in,
// exact signed Q24.16 sum out.
// Command channel: an item is taken when start is high and busy is low.
//   i_op selects: write mask tap, write image pixel, compute output pixel.
//   Writes complete in the accept cycle and leave busy low; unused op and
//   writes outside the stores are dropped.
// A compute raises busy and steps one multiply-accumulate per mask tap
//   through a single shared multiplier, reading one tap and one pixel per
//   cycle from the two RAMs. Out-of-image taps read 1.0 when one coordinate
//   is outside and 0 when both are.
// Result: the word appears on o_result_value with o_result_valid high for
//   one cycle; busy falls in that same cycle, so a new compute is taken
//   only after the result of the last one. The tap count set by the mask
//   size bounds the compute time.
// The receiver cannot stall: the result is lost if not taken that cycle.
// Config port: sizes are written by index; the user must write them only while
//   busy is low, the block does not enforce it; a compute latches them at start.
// Reset (synchronous, active low) clears the sequencer and loads image size
//   4 and mask size 3; RAM contents are undefined until written.
module conv2d_edge_one_corner_zero_pad #(
    parameter int MAX_N = 64,
    parameter int MAX_M = 7
) (
    input  wire logic                                    i_clk,
    input  wire logic                                    i_rst_n,
    input  wire logic                                    start,
    output logic                                         busy,
    input  wire logic [c2dpad_pkg::OP_W-1:0]             i_op,
    input  wire logic [c2dpad_pkg::COORD_W-1:0]          i_row,
    input  wire logic [c2dpad_pkg::COORD_W-1:0]          i_col,
    input  wire logic signed [c2dpad_pkg::VALUE_W-1:0]   i_value,
    output logic                                         o_result_valid,
    output logic signed [c2dpad_pkg::RESULT_W-1:0]       o_result_value,
    input  wire logic                                    i_cfg_we,
    input  wire logic [c2dpad_pkg::CFG_IDX_W-1:0]        i_cfg_index,
    input  wire logic [c2dpad_pkg::CFG_W-1:0]            i_cfg_data
);
    import c2dpad_pkg::*;

    localparam int IDEPTH = MAX_N * MAX_N;
    localparam int TDEPTH = MAX_M * MAX_M;
    localparam int IAW    = (IDEPTH > 1) ? $clog2(IDEPTH) : 1;
    localparam int TAW    = (TDEPTH > 1) ? $clog2(TDEPTH) : 1;

    logic [IMG_SIZE_W-1:0]  r_image_size;
    logic [MASK_SIZE_W-1:0] r_mask_size;

    logic                   s_accept, s_go;
    logic                   s_mask_we, s_image_we;
    logic [TAW-1:0]         s_mask_waddr, s_mask_raddr;
    logic [IAW-1:0]         s_image_waddr, s_image_raddr;
    logic [VALUE_W-1:0]     s_tap_data, s_pixel_data;
    logic                   s_done;
    t_tap                   s_tap;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_image_size <= IMAGE_SIZE_RST;
            r_mask_size  <= MASK_SIZE_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_IMAGE_SIZE: r_image_size <= i_cfg_data;
                REG_MASK_SIZE:  r_mask_size  <= i_cfg_data[MASK_SIZE_W-1:0];
                default: begin
                end
            endcase
        end
    end

    assign s_accept   = start && !busy;
    assign s_go       = s_accept && (i_op == OP_COMPUTE);
    assign s_mask_we  = s_accept && (i_op == OP_WR_MASK)
                        && (32'(i_row) < MAX_M) && (32'(i_col) < MAX_M);
    assign s_image_we = s_accept && (i_op == OP_WR_IMAGE)
                        && (32'(i_row) < MAX_N) && (32'(i_col) < MAX_N);

    assign s_mask_waddr  = TAW'(32'(i_row) * MAX_M + 32'(i_col));
    assign s_image_waddr = IAW'(32'(i_row) * MAX_N + 32'(i_col));

    c2dpad_ram #(
        .WIDTH (VALUE_W),
        .DEPTH (TDEPTH)
    ) u_mask_ram (
        .i_clk   (i_clk),
        .i_we    (s_mask_we),
        .i_waddr (s_mask_waddr),
        .i_wdata (i_value),
        .i_raddr (s_mask_raddr),
        .o_rdata (s_tap_data)
    );

    c2dpad_ram #(
        .WIDTH (VALUE_W),
        .DEPTH (IDEPTH)
    ) u_image_ram (
        .i_clk   (i_clk),
        .i_we    (s_image_we),
        .i_waddr (s_image_waddr),
        .i_wdata (i_value),
        .i_raddr (s_image_raddr),
        .o_rdata (s_pixel_data)
    );

    c2dpad_seq #(
        .MAX_N (MAX_N),
        .MAX_M (MAX_M),
        .IAW   (IAW),
        .TAW   (TAW)
    ) u_seq (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_go          (s_go),
        .i_row         (i_row),
        .i_col         (i_col),
        .i_image_size  (r_image_size),
        .i_mask_size   (r_mask_size),
        .i_done        (s_done),
        .o_busy        (busy),
        .o_tap         (s_tap),
        .o_mask_raddr  (s_mask_raddr),
        .o_image_raddr (s_image_raddr)
    );

    c2dpad_mac u_mac (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_tap          (s_tap),
        .i_tap_data     ($signed(s_tap_data)),
        .i_pixel_data   ($signed(s_pixel_data)),
        .o_done         (s_done),
        .o_result_valid (o_result_valid),
        .o_result_value (o_result_value)
    );

endmodule
`default_nettype wire

### test/conv2d_edge_one_corner_zero_pad_tb.sv
`timescale 1ns / 100ps

module conv2d_edge_one_corner_zero_pad_tb;
    import c2dpad_pkg::*;

    localparam int MAX_N = 64;
    localparam int MAX_M = 7;
    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

    logic                        i_clk = 1'b0;
    logic                        i_rst_n = 1'b0;
    logic                        start = 1'b0;
    logic                        busy;
    logic [OP_W-1:0]             i_op = '0;
    logic [COORD_W-1:0]          i_row = '0;
    logic [COORD_W-1:0]          i_col = '0;
    logic signed [VALUE_W-1:0]   i_value = '0;
    logic                        o_result_valid;
    logic signed [RESULT_W-1:0]  o_result_value;
    logic                        i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]        i_cfg_index = '0;
    logic [CFG_W-1:0]            i_cfg_data = '0;

    // shadow of the block's stores and size registers
    logic signed [VALUE_W-1:0]   img_px [MAX_N][MAX_N];
    logic signed [VALUE_W-1:0]   mask_tap [MAX_M][MAX_M];
    bit                          img_known [MAX_N][MAX_N];
    bit                          tap_known [MAX_M][MAX_M];
    logic [IMG_SIZE_W-1:0]       image_size_q = IMAGE_SIZE_RST;
    logic [MASK_SIZE_W-1:0]      mask_size_q = MASK_SIZE_RST;

    logic [RESULT_W-1:0]         pending_sums [$];
    int                          mismatches = 0;
    bit                          no_gaps = 1'b0;

    conv2d_edge_one_corner_zero_pad #(
        .MAX_N(MAX_N),
        .MAX_M(MAX_M)
    ) uut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .start(start),
        .busy(busy),
        .i_op(i_op),
        .i_row(i_row),
        .i_col(i_col),
        .i_value(i_value),
        .o_result_valid(o_result_valid),
        .o_result_value(o_result_value),
        .i_cfg_we(i_cfg_we),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data(i_cfg_data)
    );

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        #4_000_000;
        $display("conv2d_edge_one_corner_zero_pad: mismatch");
        $finish;
    end

    function automatic int side_n();
        if (image_size_q == 0) return 1;
        if (image_size_q > MAX_N) return MAX_N;
        return int'(image_size_q);
    endfunction

    function automatic int side_m();
        if (mask_size_q == 0) return 1;
        if (mask_size_q > MAX_M) return MAX_M;
        return int'(mask_size_q);
    endfunction

    function automatic logic signed [VALUE_W-1:0] rand_q88();
        case ($urandom_range(0, 7))
            0: return 16'h8000;
            1: return 16'h7fff;
            default: return VALUE_W'($urandom);
        endcase
    endfunction

    // exact sum of products; one coordinate out reads 1.0, both out read 0
    function automatic logic [RESULT_W-1:0] conv_sum(int r, int c);
        int     n;
        int     m;
        int     h;
        int     pr;
        int     pc;
        bit     rout;
        bit     cout;
        longint px;
        longint acc;
        n = side_n();
        m = side_m();
        h = (m - 1) / 2;
        acc = 0;
        for (int a = 0; a < m; a++) begin
            for (int b = 0; b < m; b++) begin
                pr = r + a - h;
                pc = c + b - h;
                rout = (pr < 0) || (pr > n - 1);
                cout = (pc < 0) || (pc > n - 1);
                if (rout && cout) px = 0;
                else if (rout || cout) px = PAD_ONE_VALUE;
                else px = img_px[pr][pc];
                acc += longint'(mask_tap[a][b]) * px;
            end
        end
        return acc[RESULT_W-1:0];
    endfunction

    function automatic int pick_coord(int n);
        int k;
        k = $urandom_range(0, 9);
        if (n <= 12) begin
            if (k < 7) return $urandom_range(0, n - 1);
            return $urandom_range(0, 63);
        end
        // keep large images near the edges so few pixels need filling
        if (k < 5) return $urandom_range(0, 4);
        return $urandom_range(n - 5, n - 1);
    endfunction

    task automatic idle_gap(int cycles);
        repeat (cycles) begin
            @(negedge i_clk);
            start <= 1'b0;
            i_op <= OP_W'($urandom);
            i_row <= COORD_W'($urandom);
            i_col <= COORD_W'($urandom);
            i_value <= VALUE_W'($urandom);
        end
    endtask

    task automatic issue_word(input logic [OP_W-1:0] op, input int row, input int col,
                              input logic signed [VALUE_W-1:0] value);
        if (!no_gaps && $urandom_range(0, 99) < 37)
            idle_gap(($urandom_range(0, 3) == 0) ? $urandom_range(1, 55) : $urandom_range(1, 4));
        @(negedge i_clk);
        start <= 1'b1;
        i_op <= op;
        i_row <= row[COORD_W-1:0];
        i_col <= col[COORD_W-1:0];
        i_value <= value;
        do @(posedge i_clk); while (busy !== 1'b0);
        case (op)
            OP_WR_MASK: begin
                if (row < MAX_M && col < MAX_M) begin
                    mask_tap[row][col] = value;
                    tap_known[row][col] = 1'b1;
                end
            end
            OP_WR_IMAGE: begin
                if (row < MAX_N && col < MAX_N) begin
                    img_px[row][col] = value;
                    img_known[row][col] = 1'b1;
                end
            end
            OP_COMPUTE: pending_sums.push_back(conv_sum(row, col));
            default: ;
        endcase
    endtask

    // write whatever taps and pixels the window still lacks, then compute
    task automatic do_compute(int r, int c);
        int n;
        int m;
        int h;
        int pr;
        int pc;
        n = side_n();
        m = side_m();
        h = (m - 1) / 2;
        for (int a = 0; a < m; a++) begin
            for (int b = 0; b < m; b++) begin
                if (!tap_known[a][b])
                    issue_word(OP_WR_MASK, a, b, rand_q88());
                pr = r + a - h;
                pc = c + b - h;
                if (pr >= 0 && pr < n && pc >= 0 && pc < n && !img_known[pr][pc])
                    issue_word(OP_WR_IMAGE, pr, pc, rand_q88());
            end
        end
        issue_word(OP_COMPUTE, r, c, VALUE_W'($urandom));
    endtask

    task automatic settle();
        @(negedge i_clk);
        start <= 1'b0;
        while (pending_sums.size() != 0 || busy !== 1'b0) @(posedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic set_size(input logic [CFG_IDX_W-1:0] index, input logic [CFG_W-1:0] data);
        settle();
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data <= data;
        @(posedge i_clk);
        if (index == REG_IMAGE_SIZE) image_size_q = data[IMG_SIZE_W-1:0];
        else mask_size_q = data[MASK_SIZE_W-1:0];
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic test_edges_and_ops();
        issue_word(OP_UNUSED, 63, 63, 16'h7fff);
        // out of the tap store: drop
        issue_word(OP_WR_MASK, MAX_M, 0, 16'h7fff);
        issue_word(OP_WR_MASK, 0, 63, 16'h8000);
        for (int a = 0; a < 3; a++)
            for (int b = 0; b < 3; b++)
                issue_word(OP_WR_MASK, a, b, ((a + b) % 2 == 0) ? 16'h8000 : 16'h7fff);
        issue_word(OP_WR_IMAGE, 0, 0, 16'h7fff);
        issue_word(OP_WR_IMAGE, 3, 3, 16'h8000);
        issue_word(OP_WR_IMAGE, 63, 63, 16'h0001);
        do_compute(0, 0);
        do_compute(3, 3);
        do_compute(0, 4);
        do_compute(4, 0);
        do_compute(1, 2);
        do_compute(63, 63);
        issue_word(OP_UNUSED, 0, 0, 16'h0000);
    endtask

    task automatic test_full_scale();
        set_size(REG_IMAGE_SIZE, 7'd64);
        set_size(REG_MASK_SIZE, 7'd7);
        for (int a = 0; a < MAX_M; a++)
            for (int b = 0; b < MAX_M; b++) begin
                issue_word(OP_WR_MASK, a, b, 16'h8000);
                issue_word(OP_WR_IMAGE, a, b, 16'h8000);
            end
        do_compute(3, 3);
        for (int a = 0; a < MAX_M; a++)
            for (int b = 0; b < MAX_M; b++)
                issue_word(OP_WR_MASK, a, b, 16'h7fff);
        do_compute(3, 3);
        do_compute(0, 0);
    endtask

    task automatic test_size_clamps();
        set_size(REG_IMAGE_SIZE, 7'd0);
        set_size(REG_MASK_SIZE, 7'd0);
        do_compute(0, 0);
        do_compute(0, 1);
        do_compute(1, 0);
        do_compute(5, 63);
        // upper data bits of the mask size are dropped
        set_size(REG_MASK_SIZE, 7'b1111_110);
        do_compute(0, 0);
        do_compute(2, 1);
        set_size(REG_IMAGE_SIZE, 7'd127);
        set_size(REG_MASK_SIZE, 7'b1010_010);
        do_compute(0, 0);
        do_compute(63, 63);
        do_compute(62, 0);
    endtask

    task automatic run_phase(int n_reg, int m_reg, int items, bit steady);
        int n;
        int roll;
        set_size(REG_IMAGE_SIZE, CFG_W'(n_reg));
        set_size(REG_MASK_SIZE, {4'($urandom), 3'(m_reg)});
        no_gaps = steady;
        n = side_n();
        for (int i = 0; i < items; i++) begin
            roll = $urandom_range(0, 99);
            if (roll < 50)
                do_compute(pick_coord(n), pick_coord(n));
            else if (roll < 70)
                issue_word(OP_WR_IMAGE, pick_coord(n), pick_coord(n), rand_q88());
            else if (roll < 88)
                issue_word(OP_WR_MASK,
                           ($urandom_range(0, 4) == 0) ? $urandom_range(0, 63)
                                                       : $urandom_range(0, MAX_M - 1),
                           ($urandom_range(0, 4) == 0) ? $urandom_range(0, 63)
                                                       : $urandom_range(0, MAX_M - 1),
                           rand_q88());
            else
                issue_word(OP_UNUSED, $urandom_range(0, 63), $urandom_range(0, 63),
                           VALUE_W'($urandom));
        end
        no_gaps = 1'b0;
    endtask

    task automatic test_random_traffic();
        run_phase(4, 3, 100, 1'b0);
        run_phase(1, 1, 60, 1'b0);
        run_phase(8, 5, 120, 1'b1);
        run_phase(0, 0, 40, 1'b0);
        run_phase(64, 7, 60, 1'b0);
        run_phase(127, 2, 50, 1'b0);
        run_phase(5, 7, 100, 1'b0);
        run_phase(13, 4, 90, 1'b0);
        run_phase(3, 6, 80, 1'b0);
        run_phase(2, 3, 60, 1'b0);
    endtask

    always @(posedge i_clk) begin
        logic [RESULT_W-1:0] want;
        if (i_rst_n === 1'b1 && o_result_valid === 1'b1) begin
            if (pending_sums.size() == 0) begin
                $display("%0t: unexpected pixel sum: expected none, got %h",
                         $time, o_result_value);
                mismatches++;
            end else begin
                want = pending_sums.pop_front();
                if (o_result_value !== want) begin
                    $display("%0t: pixel sum: expected %h, got %h",
                             $time, want, o_result_value);
                    mismatches++;
                end
            end
        end
    end

    initial begin
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        test_edges_and_ops();
        test_full_scale();
        test_size_clamps();
        test_random_traffic();
        settle();
        // hold long enough for a stray late word to show up
        repeat (60) @(posedge i_clk);
        if (mismatches == 0 && pending_sums.size() == 0) begin
            $display("conv2d_edge_one_corner_zero_pad: match");
        end else begin
            $display("conv2d_edge_one_corner_zero_pad: mismatch");
        end
        $finish;
    end

endmodule
